// ===== rtl/triangle_oscillator_macros.svh =====
// Assertion helpers for the checker file of the triangle oscillator.
`ifndef TRIANGLE_OSCILLATOR_MACROS_SVH
`define TRIANGLE_OSCILLATOR_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define TOSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("triangle_oscillator: next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define TOSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("triangle_oscillator: same-cycle check failed");

`endif

// ===== rtl/tosc_pkg.sv =====
`default_nettype none

package tosc_pkg;

  // Field and state widths
  localparam int unsigned FREQ_W          = 24;
  localparam int unsigned FREQ_FRAC_BITS  = 8;
  localparam int unsigned RATE_W          = 18;
  localparam int unsigned PERIOD_W        = 32;
  localparam int unsigned RATIO_FRAC_BITS = 16;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  // Parameter defaults
  localparam int unsigned PHASE_FRAC_BITS_DEF = 16;
  localparam int unsigned OUT_WIDTH_DEF       = 16;

  // Divider iteration counts
  localparam int unsigned ITER_W = 6;
  localparam logic [ITER_W-1:0] PERIOD_ITERS = ITER_W'(PERIOD_W);
  localparam logic [ITER_W-1:0] RATIO_ITERS  = ITER_W'(RATIO_FRAC_BITS);

  // Divider command
  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_cmd_t;

  // Output stage command
  typedef struct packed {
    logic load;
    logic zero;
  } shape_cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PERIOD,
    ST_PH_ADD,
    ST_PH_WRAP,
    ST_RATIO_CHK,
    ST_RATIO,
    ST_OUT
  } tosc_state_e;

endpackage

`default_nettype wire

// ===== rtl/tosc_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// The initial remainder must be below the divisor.
module tosc_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tosc_pkg::div_cmd_t               cmd_i,
  input  wire logic [tosc_pkg::PERIOD_W-1:0]    rem_init_i,
  input  wire logic [tosc_pkg::PERIOD_W-1:0]    dividend_i,
  input  wire logic [tosc_pkg::PERIOD_W-1:0]    divisor_i,
  output logic                                  done_o,
  output logic [tosc_pkg::PERIOD_W-1:0]         quotient_o
);

  localparam int unsigned W = tosc_pkg::PERIOD_W;

  logic [W-1:0]                rem_q, rem_d;
  logic [W-1:0]                shf_q, shf_d;
  logic [W-1:0]                dvs_q;
  logic [tosc_pkg::ITER_W-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [W:0]                  trial;
  logic                        take;

  // One trial subtraction per cycle
  always_comb begin
    trial = {rem_q, shf_q[W-1]} - {1'b0, dvs_q};
    take  = ~trial[W];
    rem_d = take ? trial[W-1:0] : {rem_q[W-2:0], shf_q[W-1]};
    shf_d = {shf_q[W-2:0], take};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tosc_pkg::ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= rem_init_i;
      shf_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      shf_q <= shf_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shf_q;

endmodule

`default_nettype wire

// ===== rtl/tosc_shape.sv =====
`default_nettype none

// Folds the phase ratio into a triangle and holds the result item.
module tosc_shape #(
  parameter int unsigned OUT_WIDTH = tosc_pkg::OUT_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tosc_pkg::shape_cmd_t                 cmd_i,
  input  wire logic [tosc_pkg::RATIO_FRAC_BITS:0]   ratio_i,
  input  wire logic                                 out_stall_i,
  output logic                                      out_free_o,
  output logic                                      out_valid_o,
  output logic signed [OUT_WIDTH-1:0]               wave_sample_o
);

  localparam int unsigned RF = tosc_pkg::RATIO_FRAC_BITS;
  localparam int unsigned AW = RF + 3;          // 4 * ratio
  localparam int unsigned FW = RF + 2;          // folded value, up to 2.0
  localparam int unsigned UW = FW + OUT_WIDTH - 1;

  localparam logic [AW-1:0] A_TWO  = AW'(1) << (RF + 1);
  localparam logic [AW-1:0] A_FOUR = AW'(1) << (RF + 2);
  localparam logic [OUT_WIDTH-1:0] POS_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};

  logic [AW-1:0]        a_raw;
  logic [AW-1:0]        a_fold;
  logic [UW-1:0]        u_full;
  logic [OUT_WIDTH:0]   u;
  logic [OUT_WIDTH-1:0] wave_d;
  logic [OUT_WIDTH-1:0] wave_q;
  logic                 valid_q;

  // Triangle fold and scale to the output format, or zero on command
  always_comb begin
    a_raw  = {ratio_i, 2'b00};
    a_fold = (a_raw > A_TWO) ? (A_FOUR - a_raw) : a_raw;
    u_full = {a_fold[FW-1:0], {(OUT_WIDTH-1){1'b0}}};
    u      = u_full[UW-1:RF];
    if (cmd_i.zero) begin
      wave_d = '0;
    end else if (u[OUT_WIDTH]) begin
      wave_d = POS_MAX;
    end else begin
      // subtracting half flips the top bit
      wave_d = {~u[OUT_WIDTH-1], u[OUT_WIDTH-2:0]};
    end
  end

  assign out_free_o = ~valid_q | ~out_stall_i;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wave_q <= wave_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign wave_sample_o = $signed(wave_q);

endmodule

`default_nettype wire

// ===== rtl/triangle_oscillator.sv =====
// Triangle oscillator: one output item per frequency item, one item in flight.
// A zero frequency skips the divider; otherwise the shared 1-bit-per-cycle divider
// finds the period when the frequency changes and does not saturate, then the ratio
// unless it clamps. A new item is taken in the cycle after the result is loaded.
// Reset: phase, period and last frequency clear to zero, sample rate to 48000,
// no output item pending.
`default_nettype none

module triangle_oscillator #(
  parameter int unsigned PHASE_FRAC_BITS = tosc_pkg::PHASE_FRAC_BITS_DEF,
  parameter int unsigned OUT_WIDTH       = tosc_pkg::OUT_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tosc_pkg::RATE_W-1:0]       sample_rate_hz_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [tosc_pkg::FREQ_W-1:0]       frequency_i,
  // result items
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [OUT_WIDTH-1:0]            wave_sample_o
);

  localparam int unsigned PW     = tosc_pkg::PERIOD_W;
  localparam int unsigned RF     = tosc_pkg::RATIO_FRAC_BITS;
  localparam int unsigned NUM_W  = tosc_pkg::RATE_W + tosc_pkg::FREQ_FRAC_BITS
                                   + PHASE_FRAC_BITS;
  localparam logic [PW:0]   PH_STEP   = (PW+1)'(1) << PHASE_FRAC_BITS;
  localparam logic [PW-1:0] PERIOD_MAX = '1;
  localparam logic [RF:0]   RATIO_ONE = (RF+1)'(1) << RF;

  tosc_pkg::tosc_state_e state_q, state_d;

  logic [tosc_pkg::RATE_W-1:0] rate_q;
  logic [tosc_pkg::FREQ_W-1:0] freq_q;
  logic [tosc_pkg::FREQ_W-1:0] last_q;
  logic [PW-1:0]               period_q;
  logic [PW-1:0]               phase_q;
  logic [PW:0]                 ph_q;
  logic [RF:0]                 ratio_q;
  logic                        zero_q;

  logic [NUM_W-1:0] num;
  logic             freq_zero;
  logic             freq_new;
  logic             period_sat;
  logic             ratio_clamp;
  logic [PW:0]      ph_wrapped;
  logic             in_acc;

  tosc_pkg::div_cmd_t   div_cmd;
  tosc_pkg::shape_cmd_t shape_cmd;
  logic [PW-1:0]        div_rem_init;
  logic [PW-1:0]        div_dividend;
  logic [PW-1:0]        div_divisor;
  logic                 div_done;
  logic [PW-1:0]        div_quot;
  logic                 out_free;

  // Decisions taken by the sequencer
  always_comb begin
    num         = NUM_W'(rate_q) << (tosc_pkg::FREQ_FRAC_BITS + PHASE_FRAC_BITS);
    freq_zero   = (freq_q == '0);
    freq_new    = (freq_q != last_q);
    period_sat  = (PW'(num[NUM_W-1:PW]) >= PW'(freq_q));
    ratio_clamp = (phase_q >= period_q);
    ph_wrapped  = (ph_q > {1'b0, period_q}) ? (ph_q - {1'b0, period_q}) : ph_q;
    in_acc      = in_valid_i & ~in_stall_o;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tosc_pkg::ST_IDLE: begin
        if (in_acc) state_d = tosc_pkg::ST_CHECK;
      end
      tosc_pkg::ST_CHECK: begin
        if (freq_zero) begin
          state_d = tosc_pkg::ST_OUT;
        end else if (freq_new && !period_sat) begin
          state_d = tosc_pkg::ST_PERIOD;
        end else begin
          state_d = tosc_pkg::ST_PH_ADD;
        end
      end
      tosc_pkg::ST_PERIOD: begin
        if (div_done) state_d = tosc_pkg::ST_PH_ADD;
      end
      tosc_pkg::ST_PH_ADD:  state_d = tosc_pkg::ST_PH_WRAP;
      tosc_pkg::ST_PH_WRAP: state_d = tosc_pkg::ST_RATIO_CHK;
      tosc_pkg::ST_RATIO_CHK: begin
        state_d = ratio_clamp ? tosc_pkg::ST_OUT : tosc_pkg::ST_RATIO;
      end
      tosc_pkg::ST_RATIO: begin
        if (div_done) state_d = tosc_pkg::ST_OUT;
      end
      tosc_pkg::ST_OUT: begin
        if (out_free) state_d = tosc_pkg::ST_IDLE;
      end
      default: state_d = tosc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o     = 1'b1;
    div_cmd.start  = 1'b0;
    div_cmd.iters  = tosc_pkg::PERIOD_ITERS;
    div_rem_init   = PW'(num[NUM_W-1:PW]);
    div_dividend   = num[PW-1:0];
    div_divisor    = PW'(freq_q);
    shape_cmd.load = 1'b0;
    shape_cmd.zero = zero_q;
    unique case (state_q)
      tosc_pkg::ST_IDLE: in_stall_o = 1'b0;
      tosc_pkg::ST_CHECK: begin
        div_cmd.start = ~freq_zero & freq_new & ~period_sat;
      end
      tosc_pkg::ST_RATIO_CHK: begin
        div_cmd.start = ~ratio_clamp;
        div_cmd.iters = tosc_pkg::RATIO_ITERS;
        div_rem_init  = phase_q;
        div_dividend  = '0;
        div_divisor   = period_q;
      end
      tosc_pkg::ST_OUT: shape_cmd.load = out_free;
      default: ;
    endcase
  end

  // Control state and oscillator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tosc_pkg::ST_IDLE;
      rate_q   <= tosc_pkg::RATE_RESET;
      last_q   <= '0;
      period_q <= '0;
      phase_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        rate_q <= sample_rate_hz_i;
      end
      unique case (state_q)
        tosc_pkg::ST_CHECK: begin
          if (freq_zero) begin
            phase_q <= '0;
            last_q  <= '0;
          end else if (freq_new) begin
            last_q <= freq_q;
            if (period_sat) period_q <= PERIOD_MAX;
          end
        end
        tosc_pkg::ST_PERIOD: begin
          if (div_done) period_q <= div_quot;
        end
        tosc_pkg::ST_PH_WRAP: begin
          phase_q <= ph_wrapped[PW] ? PERIOD_MAX : ph_wrapped[PW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Per-item working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      freq_q <= frequency_i;
    end
    if (state_q == tosc_pkg::ST_CHECK) begin
      zero_q <= freq_zero;
    end
    if (state_q == tosc_pkg::ST_PH_ADD) begin
      ph_q <= {1'b0, phase_q} + PH_STEP;
    end
    if (state_q == tosc_pkg::ST_RATIO_CHK && ratio_clamp) begin
      ratio_q <= RATIO_ONE;
    end else if (state_q == tosc_pkg::ST_RATIO && div_done) begin
      ratio_q <= {1'b0, div_quot[RF-1:0]};
    end
  end

  assign cfg_ready_o = 1'b1;

  tosc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  tosc_shape #(
    .OUT_WIDTH (OUT_WIDTH)
  ) u_shape (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (shape_cmd),
    .ratio_i       (ratio_q),
    .out_stall_i   (out_stall_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .wave_sample_o (wave_sample_o)
  );

endmodule

`default_nettype wire

// ===== rtl/tosc_checker.sv =====
`default_nettype none
`include "triangle_oscillator_macros.svh"

// Port-level checks for the triangle oscillator.
module tosc_checker #(
  parameter int unsigned OUT_WIDTH = tosc_pkg::OUT_WIDTH_DEF
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic signed [OUT_WIDTH-1:0] wave_sample_o
);

  // one item in flight: busy right after an accept
  `TOSC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // a result never appears in the cycle after an accept
  `TOSC_ASSERT_NEXT(a_no_result_on_accept, in_valid_i && !in_stall_o, !$rose(out_valid_o))
  // a new result is produced only while the input side is busy
  `TOSC_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))
  // a stalled result stays put
  `TOSC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(wave_sample_o))

endmodule

bind triangle_oscillator tosc_checker #(
  .OUT_WIDTH (OUT_WIDTH)
) u_tosc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .wave_sample_o (wave_sample_o)
);

`default_nettype wire
